>>> rtl/wmsd_pkg.sv
// ----------------------------------------------------------------------------
// wmsd_pkg
// Shared types and constants for the windowed mean / sdev block.
// ----------------------------------------------------------------------------
package wmsd_pkg;

  localparam int SAMPLE_W = 16;
  localparam int KH_W     = 4;
  localparam int MEAN_W   = 20;
  localparam int SDEV_W   = 19;
  localparam int FRAC_W   = 4;    // fraction bits of mean and sdev
  localparam int VSCALE_W = 8;    // 256 = 2^(2*FRAC_W) scale on the variance
  localparam logic [KH_W-1:0] KH_RESET = 4'd4;

  // top level sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACC,
    ST_CALC,
    ST_EMIT
  } top_state_t;

  // arithmetic unit sequencer
  typedef enum logic [2:0] {
    SS_IDLE,
    SS_MUL,
    SS_SUB,
    SS_DIV,
    SS_SQRT,
    SS_DONE
  } stat_state_t;

  // statistics handed from the arithmetic unit to the top level
  typedef struct packed {
    logic signed [MEAN_W-1:0] mean;
    logic                     mean_valid;
    logic [SDEV_W-1:0]        sdev;
    logic                     sdev_valid;
  } stat_t;

endpackage

>>> rtl/wmsd_ram.sv
// ----------------------------------------------------------------------------
// wmsd_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module wmsd_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 31
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/wmsd_stats.sv
// ----------------------------------------------------------------------------
// wmsd_stats
// Mean and standard deviation from window sums: one product stage, two
// bit-serial restoring dividers run side by side, then a 2-bit-per-step
// integer square root.
// ----------------------------------------------------------------------------
module wmsd_stats #(
  parameter int CNT_W = 5
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [wmsd_pkg::SAMPLE_W+CNT_W-1:0] sum,
  input  logic [2*wmsd_pkg::SAMPLE_W+CNT_W-1:0]      sumsq,
  input  logic [CNT_W-1:0]                  n,
  output logic                              done,
  output wmsd_pkg::stat_t                   res
);

  localparam int SUM_W = wmsd_pkg::SAMPLE_W + CNT_W;
  localparam int SQ_W  = 2 * wmsd_pkg::SAMPLE_W + CNT_W;
  localparam int NUM_W = SQ_W + CNT_W;
  localparam int VD_W  = NUM_W + wmsd_pkg::VSCALE_W;
  localparam int RT_W  = VD_W / 2;
  localparam int MG_W  = SUM_W - 1;
  localparam int MD_W  = MG_W + wmsd_pkg::FRAC_W;
  localparam int DV_W  = 2 * CNT_W;
  localparam int IT_W  = $clog2(VD_W + 1);

  wmsd_pkg::stat_state_t state, state_next;

  logic [IT_W-1:0]   it;
  logic              neg;
  logic [CNT_W-1:0]  n_r;
  logic [MG_W-1:0]   mag;
  logic [SQ_W-1:0]   sq_r;
  logic [NUM_W-1:0]  prod;
  logic [NUM_W-1:0]  sum2;
  logic [DV_W-1:0]   dn;
  logic [MD_W-1:0]   md;
  logic [CNT_W-1:0]  mrem;
  logic [VD_W-1:0]   vd;
  logic [DV_W-1:0]   vrem;
  logic [RT_W-1:0]   rt;
  logic [RT_W+1:0]   rrem;
  logic [VD_W-1:0]   rx;

  // divider and root steps
  logic [CNT_W:0]    m_r2;
  logic              m_ge;
  logic [DV_W:0]     v_r2;
  logic              v_ge;
  logic [RT_W+3:0]   r_t;
  logic [RT_W+3:0]   r_trial;
  logic              r_ge;
  logic [SUM_W-1:0]  sum_abs;

  assign sum_abs = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);

  assign m_r2    = {mrem, md[MD_W-1]};
  assign m_ge    = m_r2 >= {1'b0, n_r};
  assign v_r2    = {vrem, vd[VD_W-1]};
  assign v_ge    = v_r2 >= {1'b0, dn};
  assign r_t     = {rrem, rx[VD_W-1:VD_W-2]};
  assign r_trial = {2'b00, rt, 2'b01};
  assign r_ge    = r_t >= r_trial;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      wmsd_pkg::SS_IDLE: if (start) state_next = wmsd_pkg::SS_MUL;
      wmsd_pkg::SS_MUL:  state_next = wmsd_pkg::SS_SUB;
      wmsd_pkg::SS_SUB:  state_next = wmsd_pkg::SS_DIV;
      wmsd_pkg::SS_DIV:  if (it == IT_W'(VD_W)) state_next = wmsd_pkg::SS_SQRT;
      wmsd_pkg::SS_SQRT: if (it == IT_W'(RT_W)) state_next = wmsd_pkg::SS_DONE;
      wmsd_pkg::SS_DONE: state_next = wmsd_pkg::SS_IDLE;
      default:           state_next = wmsd_pkg::SS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wmsd_pkg::SS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      wmsd_pkg::SS_IDLE: begin
        n_r  <= n;
        neg  <= sum[SUM_W-1];
        mag  <= sum_abs[MG_W-1:0];
        sq_r <= sumsq;
      end
      wmsd_pkg::SS_MUL: begin
        prod <= NUM_W'(n_r * sq_r);
        sum2 <= NUM_W'(mag * mag);
        dn   <= DV_W'(n_r * n_r);
        md   <= {mag, {wmsd_pkg::FRAC_W{1'b0}}};
        mrem <= '0;
        vrem <= '0;
        it   <= '0;
      end
      wmsd_pkg::SS_SUB: begin
        vd <= {NUM_W'(prod - sum2), {wmsd_pkg::VSCALE_W{1'b0}}};
      end
      wmsd_pkg::SS_DIV: begin
        if (it == IT_W'(VD_W)) begin
          rx   <= vd;
          rt   <= '0;
          rrem <= '0;
          it   <= '0;
        end else begin
          vd   <= {vd[VD_W-2:0], v_ge};
          vrem <= v_ge ? DV_W'(v_r2 - {1'b0, dn}) : v_r2[DV_W-1:0];
          if (it < IT_W'(MD_W)) begin
            md   <= {md[MD_W-2:0], m_ge};
            mrem <= m_ge ? CNT_W'(m_r2 - {1'b0, n_r}) : m_r2[CNT_W-1:0];
          end
          it <= it + 1'b1;
        end
      end
      wmsd_pkg::SS_SQRT: begin
        if (it != IT_W'(RT_W)) begin
          rrem <= r_ge ? (RT_W+2)'(r_t - r_trial) : r_t[RT_W+1:0];
          rt   <= {rt[RT_W-2:0], r_ge};
          rx   <= {rx[VD_W-3:0], 2'b00};
          it   <= it + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // results
  logic [wmsd_pkg::MEAN_W-1:0] mean_mag;
  assign mean_mag = md[wmsd_pkg::MEAN_W-1:0];

  assign done           = (state == wmsd_pkg::SS_DONE);
  assign res.mean_valid = (n_r != '0);
  assign res.sdev_valid = (n_r > CNT_W'(2));
  assign res.mean       = !res.mean_valid ? '0 :
                          neg ? $signed(-mean_mag) : $signed(mean_mag);
  assign res.sdev       = res.sdev_valid ? rt[wmsd_pkg::SDEV_W-1:0] : '0;

endmodule

>>> rtl/windowed_mean_sdev_missing_aware.sv
// A gate that completes a window has its window read back from the store RAM,
// then passes the arithmetic unit (product, subtract, divide, root, hand-off)
// before its first result beat shows. Throughput: one gate at a time; beats go
// out one per cycle while out_ready is high, and the next gate is taken the
// cycle after the last beat. A gate that completes no window gives no beat unless
// it ends a short ray. Reset (rst, synchronous) clears control, kernel_half=4.
// ----------------------------------------------------------------------------
// windowed_mean_sdev_missing_aware
// Sliding window mean and standard deviation over radar range gates, with
// missing gates excluded. Gates live in a circular store RAM; each gate's
// window is summed by reading it back, then divided and rooted serially.
// ----------------------------------------------------------------------------
module windowed_mean_sdev_missing_aware #(
  parameter int MAX_HALF = 15,
  parameter int CNT_W    = $clog2(2 * MAX_HALF + 2)
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [wmsd_pkg::KH_W-1:0]          cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [wmsd_pkg::SAMPLE_W-1:0] sample,
  input  logic                               missing,
  input  logic                               last_gate,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [wmsd_pkg::MEAN_W-1:0] gate_mean,
  output logic                               mean_valid,
  output logic [wmsd_pkg::SDEV_W-1:0]        gate_sdev,
  output logic                               sdev_valid,
  output logic [CNT_W-1:0]                   present_count,
  output logic                               too_short,
  output logic                               last_of_run
);

  localparam int DEPTH = 2 * MAX_HALF + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int ENT_W = wmsd_pkg::SAMPLE_W + 1;
  localparam int GS_W  = $clog2(DEPTH + 2);
  localparam int SUM_W = wmsd_pkg::SAMPLE_W + CNT_W;
  localparam int SQ_W  = 2 * wmsd_pkg::SAMPLE_W + CNT_W;

  wmsd_pkg::top_state_t state, state_next;

  logic [wmsd_pkg::KH_W-1:0] kernel_half;
  logic [AW-1:0]             wp;
  logic [AW-1:0]             rd_ptr;
  logic [CNT_W-1:0]          issued;
  logic                      rd_vld;
  logic [CNT_W-1:0]          kk;
  logic [GS_W-1:0]           gates_seen;
  logic [CNT_W-1:0]          emit_left;
  logic                      short_r;
  logic signed [SUM_W-1:0]   acc_sum;
  logic [SQ_W-1:0]           acc_sq;
  logic [CNT_W-1:0]          acc_n;
  logic                      stat_start;
  logic                      stat_done;
  wmsd_pkg::stat_t           stat_res;
  wmsd_pkg::stat_t           res_r;

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_half <= wmsd_pkg::KH_RESET;
    end else if (cfg_we) begin
      kernel_half <= cfg_data;
    end
  end

  // clamp half width and derive window length
  logic [CNT_W-1:0] h_c;
  logic [CNT_W-1:0] k_c;
  logic [GS_W:0]    c_c;
  logic             full_c;
  logic             first_c;
  logic [CNT_W-1:0] count_c;

  always_comb begin
    if (kernel_half == '0) begin
      h_c = CNT_W'(1);
    end else if (32'(kernel_half) > MAX_HALF) begin
      h_c = CNT_W'(MAX_HALF);
    end else begin
      h_c = CNT_W'(kernel_half);
    end
    k_c     = CNT_W'({h_c, 1'b1});
    c_c     = (GS_W+1)'(gates_seen) + 1'b1;
    full_c  = c_c >= (GS_W+1)'(k_c);
    first_c = c_c == (GS_W+1)'(k_c);
    count_c = (first_c ? CNT_W'(h_c + 1'b1) : CNT_W'(1)) + (last_gate ? h_c : '0);
  end

  logic in_acc;
  logic out_acc;
  logic rd_en;
  logic acc_end;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;
  assign rd_en   = (state == wmsd_pkg::ST_ACC) && (issued != kk);
  assign acc_end = (state == wmsd_pkg::ST_ACC) && (issued == kk) && !rd_vld;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      wmsd_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (full_c) begin
            state_next = wmsd_pkg::ST_ACC;
          end else if (last_gate) begin
            state_next = wmsd_pkg::ST_EMIT;
          end
        end
      end
      wmsd_pkg::ST_ACC:  if (acc_end) state_next = wmsd_pkg::ST_CALC;
      wmsd_pkg::ST_CALC: if (stat_done) state_next = wmsd_pkg::ST_EMIT;
      wmsd_pkg::ST_EMIT: begin
        if (out_acc && emit_left == CNT_W'(1)) begin
          state_next = wmsd_pkg::ST_IDLE;
        end
      end
      default: state_next = wmsd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wmsd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control counters and pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wp         <= '0;
      gates_seen <= '0;
      rd_vld     <= 1'b0;
      issued     <= '0;
      emit_left  <= '0;
      short_r    <= 1'b0;
    end else begin
      rd_vld <= rd_en;
      if (in_acc) begin
        wp     <= (wp == AW'(DEPTH - 1)) ? '0 : wp + 1'b1;
        rd_ptr <= wp;
        issued <= '0;
        kk     <= k_c;
        if (last_gate) begin
          gates_seen <= '0;
        end else if (full_c) begin
          gates_seen <= GS_W'(k_c + 1'b1);
        end else begin
          gates_seen <= c_c[GS_W-1:0];
        end
        emit_left <= full_c ? count_c : CNT_W'(1);
        short_r   <= !full_c;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == '0) ? AW'(DEPTH - 1) : rd_ptr - 1'b1;
        issued <= issued + 1'b1;
      end
      if (out_acc) begin
        emit_left <= emit_left - 1'b1;
      end
    end
  end

  // window store
  logic [ENT_W-1:0] rdata;

  wmsd_ram #(
    .WIDTH (ENT_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (in_acc),
    .waddr (wp),
    .wdata ({missing, sample}),
    .re    (rd_en),
    .raddr (rd_ptr),
    .rdata (rdata)
  );

  // window sums over the present gates
  logic signed [wmsd_pkg::SAMPLE_W-1:0] rd_sample;
  logic [2*wmsd_pkg::SAMPLE_W-1:0]      rd_sq;

  assign rd_sample = $signed(rdata[wmsd_pkg::SAMPLE_W-1:0]);
  assign rd_sq     = $unsigned((2*wmsd_pkg::SAMPLE_W)'(rd_sample) *
                               (2*wmsd_pkg::SAMPLE_W)'(rd_sample));

  always_ff @(posedge clk) begin
    if (in_acc) begin
      acc_sum <= '0;
      acc_sq  <= '0;
      acc_n   <= '0;
    end else if (rd_vld && !rdata[ENT_W-1]) begin
      acc_sum <= acc_sum + SUM_W'(rd_sample);
      acc_sq  <= acc_sq + SQ_W'(rd_sq);
      acc_n   <= acc_n + 1'b1;
    end
  end

  assign stat_start = acc_end;

  wmsd_stats #(
    .CNT_W (CNT_W)
  ) u_stats (
    .clk   (clk),
    .rst   (rst),
    .start (stat_start),
    .sum   (acc_sum),
    .sumsq (acc_sq),
    .n     (acc_n),
    .done  (stat_done),
    .res   (stat_res)
  );

  // result register, cleared for the short-ray beat
  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r         <= '0;
      present_count <= '0;
    end else if (stat_done) begin
      res_r         <= stat_res;
      present_count <= acc_n;
    end
  end

  // outputs
  assign in_ready    = (state == wmsd_pkg::ST_IDLE);
  assign out_valid   = (state == wmsd_pkg::ST_EMIT);
  assign gate_mean   = res_r.mean;
  assign mean_valid  = res_r.mean_valid;
  assign gate_sdev   = res_r.sdev;
  assign sdev_valid  = res_r.sdev_valid;
  assign too_short   = short_r;
  assign last_of_run = (emit_left == CNT_W'(1));

endmodule

>>> rtl/wmsd_checker.sv
// ----------------------------------------------------------------------------
// wmsd_sva
// Port-level checks for the windowed mean / sdev block, bound to the top.
// ----------------------------------------------------------------------------
module wmsd_sva #(
  parameter int CNT_W = 5
) (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [wmsd_pkg::MEAN_W-1:0] gate_mean,
  input logic                               mean_valid,
  input logic [wmsd_pkg::SDEV_W-1:0]        gate_sdev,
  input logic                               sdev_valid,
  input logic [CNT_W-1:0]                   present_count,
  input logic                               too_short,
  input logic                               last_of_run
);

  // one gate in flight: no intake while beats are pending
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input taken while results pending");

  // a stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(gate_mean) && $stable(gate_sdev)
      && $stable(last_of_run))
    else $error("stalled result beat changed");

  // short ray gives one bare beat
  a_short: assert property (@(posedge clk) disable iff (rst)
    out_valid && too_short |-> last_of_run && !mean_valid && !sdev_valid
      && present_count == '0 && gate_mean == '0)
    else $error("short-ray beat carries statistics");

  // invalid statistics read as zero
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (mean_valid || gate_mean == '0) && (sdev_valid || gate_sdev == '0))
    else $error("invalid statistic not zero");

  // sdev needs more than two present gates
  a_sdev: assert property (@(posedge clk) disable iff (rst)
    out_valid && sdev_valid |-> mean_valid && present_count > CNT_W'(2))
    else $error("sdev valid with too few samples");

endmodule

bind windowed_mean_sdev_missing_aware wmsd_sva #(.CNT_W(CNT_W)) u_wmsd_sva (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .gate_mean     (gate_mean),
  .mean_valid    (mean_valid),
  .gate_sdev     (gate_sdev),
  .sdev_valid    (sdev_valid),
  .present_count (present_count),
  .too_short     (too_short),
  .last_of_run   (last_of_run)
);
